@@ design/hned_pkg.sv @@
`timescale 1ns / 1ps

package hned_pkg;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [6:0] VAL_MAX   = 7'd127;
  localparam logic [6:0] VAL_LOW   = 7'd32;
  localparam logic [6:0] VAL_COMMA = 7'd44;

  // byte class decided in the front end
  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_DIGIT = 3'd1,
    CLS_AMP   = 3'd2,
    CLS_HASH  = 3'd3,
    CLS_SEMI  = 3'd4,
    CLS_COMMA = 3'd5
  } hned_cls_t;

  // parser state, one-hot
  typedef enum logic [3:0] {
    ST_PLAIN   = 4'b0001,
    ST_AMP     = 4'b0010,
    ST_ENTITY  = 4'b0100,
    ST_STOPPED = 4'b1000
  } hned_state_t;

  // classified item handed from front to back through the queue
  typedef struct packed {
    hned_cls_t  cls;
    logic [3:0] digit;
    logic [7:0] data;
    logic       last;
  } hned_item_t;

endpackage

@@ design/html_numeric_entity_decoder_unit.sv @@
`timescale 1ns / 1ps

// A byte accepted on the input goes into the queue, then the parser registers its result.
// One byte per cycle unless stalled; bytes that decode to nothing still take one parser step.
// A two-entry queue between classifier and parser absorbs output stalls until it is full.
// Reset (rst, synchronous, active high) empties the queue, drops any pending
// result and returns the parser to plain text with a zero entity value.
module html_numeric_entity_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // last_of_buffer
  // result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] has_byte
  output logic       m_tlast    // end_of_text
);

  hned_pkg::hned_item_t front_item;
  hned_pkg::hned_item_t queue_item;
  logic                 queue_full;
  logic                 queue_not_empty;
  logic                 queue_pop;
  logic                 push;

  // a transaction on the input side is a push into the queue
  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;

  // front: classify each byte (digit, '&', '#', ';', ',' or other)
  hned_front u_front (
    .in_byte (s_tdata),
    .in_last (s_tlast),
    .item    (front_item)
  );

  hned_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_not_empty),
    .pop_item  (queue_item)
  );

  // back: entity parser plus output register; pops whenever the
  // output register is empty or being drained this cycle
  hned_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (queue_not_empty),
    .item       (queue_item),
    .pop        (queue_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_has    (m_tuser),
    .out_byte   (m_tdata),
    .out_end    (m_tlast)
  );

endmodule

@@ design/hned_front.sv @@
`timescale 1ns / 1ps

module hned_front (
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output hned_pkg::hned_item_t item
);

  logic [7:0] diff;

  assign diff = in_byte - hned_pkg::CH_ZERO;

  always_comb begin
    item.data  = in_byte;
    item.last  = in_last;
    item.digit = diff[3:0];
    if (in_byte >= hned_pkg::CH_ZERO && in_byte <= hned_pkg::CH_NINE) begin
      item.cls = hned_pkg::CLS_DIGIT;
    end else if (in_byte == hned_pkg::CH_AMP) begin
      item.cls = hned_pkg::CLS_AMP;
    end else if (in_byte == hned_pkg::CH_HASH) begin
      item.cls = hned_pkg::CLS_HASH;
    end else if (in_byte == hned_pkg::CH_SEMI) begin
      item.cls = hned_pkg::CLS_SEMI;
    end else if (in_byte == hned_pkg::CH_COMMA) begin
      item.cls = hned_pkg::CLS_COMMA;
    end else begin
      item.cls = hned_pkg::CLS_OTHER;
    end
  end

endmodule

@@ design/hned_fifo.sv @@
`timescale 1ns / 1ps

// two-entry queue between classifier and parser
module hned_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  hned_pkg::hned_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output hned_pkg::hned_item_t pop_item
);

  hned_pkg::hned_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ design/hned_back.sv @@
`timescale 1ns / 1ps

module hned_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  hned_pkg::hned_item_t item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_has,
  output logic [7:0]           out_byte,
  output logic                 out_end
);

  hned_pkg::hned_state_t mode, mode_next;
  logic [6:0]  entity_value, entity_value_next;
  logic [10:0] times_ten;
  logic [10:0] acc;
  logic        has;
  logic [7:0]  ch;
  logic        stop;
  logic        was_stopped;
  logic        done;
  logic        emit;

  assign pop       = item_valid && (!out_valid || out_ready);
  assign times_ten = {1'b0, entity_value, 3'b000} + {3'b000, entity_value, 1'b0};
  assign acc       = times_ten + {7'd0, item.digit};

  always_comb begin
    has               = 1'b0;
    ch                = 8'd0;
    stop              = 1'b0;
    mode_next         = mode;
    entity_value_next = entity_value;
    case (mode)
      hned_pkg::ST_PLAIN: begin
        if (item.cls == hned_pkg::CLS_AMP) begin
          mode_next = hned_pkg::ST_AMP;
        end else if (item.cls == hned_pkg::CLS_COMMA) begin
          stop = 1'b1;
        end else begin
          has = 1'b1;
          ch  = item.data;
        end
      end
      hned_pkg::ST_AMP: begin
        if (item.cls != hned_pkg::CLS_HASH) begin
          entity_value_next = hned_pkg::VAL_MAX;
        end
        mode_next = hned_pkg::ST_ENTITY;
      end
      hned_pkg::ST_ENTITY: begin
        if (item.cls == hned_pkg::CLS_DIGIT) begin
          entity_value_next = (acc >= {4'd0, hned_pkg::VAL_MAX}) ? hned_pkg::VAL_MAX
                                                                  : acc[6:0];
        end else if (item.cls == hned_pkg::CLS_SEMI) begin
          if (entity_value == hned_pkg::VAL_COMMA) begin
            stop = 1'b1;
          end else begin
            has = 1'b1;
            // control codes and invalid entities decode to a space
            ch  = (entity_value < hned_pkg::VAL_LOW || entity_value == hned_pkg::VAL_MAX)
                  ? hned_pkg::CH_SPACE : {1'b0, entity_value};
            entity_value_next = 7'd0;
            mode_next         = hned_pkg::ST_PLAIN;
          end
        end else begin
          entity_value_next = hned_pkg::VAL_MAX;
        end
      end
      hned_pkg::ST_STOPPED: begin
      end
      default: begin
        mode_next         = hned_pkg::ST_PLAIN;
        entity_value_next = 7'd0;
      end
    endcase

    was_stopped = (mode == hned_pkg::ST_STOPPED);
    if (stop) begin
      mode_next         = hned_pkg::ST_STOPPED;
      entity_value_next = 7'd0;
    end
    done = stop || (item.last && !was_stopped);
    if (item.last) begin
      mode_next         = hned_pkg::ST_PLAIN;
      entity_value_next = 7'd0;
    end
    emit = has || done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= hned_pkg::ST_PLAIN;
      entity_value <= 7'd0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        mode         <= mode_next;
        entity_value <= entity_value_next;
        out_valid    <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_has  <= has;
      out_byte <= ch;
      out_end  <= done;
    end
  end

  // the accumulator only holds a value while inside an entity
  a_value_idle: assert property (@(posedge clk) disable iff (rst)
    (mode != hned_pkg::ST_ENTITY) |-> (entity_value == 7'd0))
    else $error("entity value nonzero outside entity");

  // end of buffer always returns the parser to plain text
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (pop && item.last) |=> (mode == hned_pkg::ST_PLAIN))
    else $error("parser not reset after buffer end");

  // a stop never decodes a character in the same step
  a_stop_no_char: assert property (@(posedge clk) disable iff (rst)
    (pop && stop) |=> (out_valid && out_end && !out_has))
    else $error("stop result malformed");

  // a consumed item with output always lands in the output register
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (pop && emit) |=> out_valid)
    else $error("result lost");

endmodule
